@@ src/cnf_resolution_subsumption_engine_unit_assert.svh @@
// Assertion macros for the clause simplifier.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef CNF_RESOLUTION_SUBSUMPTION_ENGINE_UNIT_ASSERT_SVH
`define CNF_RESOLUTION_SUBSUMPTION_ENGINE_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CRSE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CRSE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/crse_pkg.sv @@
// Shared constants, types and command/status structs of the clause simplifier.
// No dependencies.
`default_nettype none
package crse_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int VAR_SLOTS   = 64;
  localparam int FIELD_W     = 64;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CW          = $clog2(TABLE_DEPTH + 1);
  localparam logic [FIELD_W-1:0] SLOT_MASK = {FIELD_W{1'b1}} >> (FIELD_W - VAR_SLOTS);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0] pos;
    logic [FIELD_W-1:0] neg;
  } clause_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_P1_CHK, ST_P1_RB, ST_P1_RES, ST_P1_KRD, ST_P1_KCHK,
    ST_P2_CHK, ST_P2_RB, ST_P2_CMP, ST_C_CHK, ST_C_WR,
    ST_P4_CHK, ST_P4_RB, ST_P4_RES, ST_P4_KRD, ST_P4_KCHK,
    ST_E_CHK, ST_E_RD, ST_E_OUT
  } state_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_LOAD, WR_REPL, WR_APPEND, WR_COPY
  } wr_op_e;

  typedef enum logic [1:0] {
    PASS_SUB, PASS_PROJ, PASS_RED
  } pass_e;

  typedef struct packed {
    logic [AW-1:0] rd_addr;
    logic          lat_a;
    logic          lat_r;
    wr_op_e        wr_op;
    logic [AW-1:0] wr_addr;
    logic          cnt_load;
    logic [CW-1:0] cnt_val;
    logic          lat_proj;
    logic          keep_all;
    logic          keep_clr;
    logic [AW-1:0] keep_addr;
    logic          emit;
    logic          emit_last;
    logic          emit_empty;
  } cmd_t;

  typedef struct packed {
    logic [CW-1:0]          cnt;
    logic                   ovf;
    logic                   r_ok;
    logic                   rd_sub_r;
    logic                   r_sub_rd;
    logic                   rd_eq_r;
    logic                   a_sub_rd;
    logic                   rd_sub_a;
    logic                   touch;
    logic [TABLE_DEPTH-1:0] keep;
  } sts_t;

endpackage
`default_nettype wire

@@ src/crse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module crse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ src/crse_datapath.sv @@
// Datapath of the clause simplifier: clause table, resolvent and subsumption
// checks, keep flags, count, overflow and result registers. Uses crse_pkg, crse_ram.
`default_nettype none
module crse_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [crse_pkg::FIELD_W-1:0]  load_positive_i,
  input  logic [crse_pkg::FIELD_W-1:0]  load_negative_i,
  input  logic [crse_pkg::FIELD_W-1:0]  project_mask_i,
  input  crse_pkg::cmd_t                cmd_i,
  output crse_pkg::sts_t                sts_o,
  output logic                          result_valid_o,
  output logic [crse_pkg::FIELD_W-1:0]  clause_positive_o,
  output logic [crse_pkg::FIELD_W-1:0]  clause_negative_o,
  output logic                          clause_present_o,
  output logic                          table_overflow_o,
  output logic                          last_clause_o
);
  import crse_pkg::*;

  function automatic logic subset(clause_t a, clause_t b);
    subset = ((a.pos & b.pos) == a.pos) && ((a.neg & b.neg) == a.neg);
  endfunction

  logic [2*FIELD_W-1:0]   rdata;
  clause_t                rd, wdata, a_q, r_q, ld;
  logic                   r_ok_q;
  logic [FIELD_W-1:0]     proj_q;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic [TABLE_DEPTH-1:0] keep_q, keep_d;
  logic                   grow, full, we;
  logic [AW-1:0]          waddr;
  logic [FIELD_W-1:0]     rp, rn, clash;
  logic                   clash_one;

  assign rd     = clause_t'(rdata);
  assign ld.pos = load_positive_i & SLOT_MASK;
  assign ld.neg = load_negative_i & SLOT_MASK;

  // Write port steering; loads and appends drop when full
  assign full  = (cnt_q == CW'(TABLE_DEPTH));
  assign grow  = (cmd_i.wr_op == WR_LOAD) || (cmd_i.wr_op == WR_APPEND);
  assign we    = grow ? !full : (cmd_i.wr_op != WR_NONE);
  assign waddr = grow ? cnt_q[AW-1:0] : cmd_i.wr_addr;

  always_comb begin
    case (cmd_i.wr_op)
      WR_LOAD:   wdata = ld;
      WR_COPY:   wdata = rd;
      default:   wdata = r_q;
    endcase
  end

  crse_ram #(
    .WIDTH(2*FIELD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(rdata)
  );

  // Resolvent of the held clause and the clause just read
  assign rp        = a_q.pos | rd.pos;
  assign rn        = a_q.neg | rd.neg;
  assign clash     = rp & rn;
  assign clash_one = (clash != '0) && ((clash & (clash - FIELD_W'(1))) == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_a) begin
      a_q <= rd;
    end
    if (cmd_i.lat_r) begin
      r_q.pos <= rp & ~clash;
      r_q.neg <= rn & ~clash;
      r_ok_q  <= clash_one;
    end
    if (cmd_i.lat_proj) begin
      proj_q <= project_mask_i & SLOT_MASK;
    end
  end

  // Count, overflow and keep flags
  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    keep_d = keep_q;
    if (cmd_i.cnt_load) begin
      cnt_d = cmd_i.cnt_val;
    end else if (grow && !full) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (grow && full) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.keep_all) begin
      keep_d = '1;
    end else if (cmd_i.keep_clr) begin
      keep_d[cmd_i.keep_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      keep_q <= '1;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      keep_q <= keep_d;
    end
  end

  // Result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      clause_positive_o <= cmd_i.emit_empty ? '0 : rd.pos;
      clause_negative_o <= cmd_i.emit_empty ? '0 : rd.neg;
      clause_present_o  <= !cmd_i.emit_empty;
      table_overflow_o  <= ovf_q;
      last_clause_o     <= cmd_i.emit_last;
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.cnt      = cnt_q;
    sts_o.ovf      = ovf_q;
    sts_o.r_ok     = r_ok_q;
    sts_o.rd_sub_r = subset(rd, r_q);
    sts_o.r_sub_rd = subset(r_q, rd);
    sts_o.rd_eq_r  = (rd == r_q);
    sts_o.a_sub_rd = subset(a_q, rd);
    sts_o.rd_sub_a = subset(rd, a_q);
    sts_o.touch    = ((rd.pos | rd.neg) & proj_q) != '0;
    sts_o.keep     = keep_q;
  end

endmodule
`default_nettype wire

@@ src/crse_ctrl.sv @@
// Controller of the clause simplifier: walks the table through the run phases
// and issues commands to the datapath. Uses crse_pkg.
`default_nettype none
module crse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           opcode_i,
  output logic           busy_o,
  output crse_pkg::cmd_t cmd_o,
  input  crse_pkg::sts_t sts_i
);
  import crse_pkg::*;

  state_e        state_q, state_d;
  pass_e         pass_q, pass_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, w_q, w_d;
  logic          k_last, e_last, keep_ok;

  assign busy_o  = (state_q != ST_IDLE);
  assign k_last  = ((k_q + CW'(1)) >= sts_i.cnt);
  assign e_last  = ((i_q + CW'(1)) >= sts_i.cnt);
  assign keep_ok = (pass_q == PASS_PROJ) ? !sts_i.touch : sts_i.keep[i_q[AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= PASS_SUB;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      w_q     <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      w_q     <= w_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    w_d     = w_q;
    cmd_o   = '0;
    cmd_o.wr_op = WR_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (opcode_i == OP_LOAD) begin
            cmd_o.wr_op = WR_LOAD;
          end else begin
            cmd_o.lat_proj = 1'b1;
            i_d = '0;
            j_d = '0;
            state_d = ST_P1_CHK;
          end
        end
      end
      // Phase 1: resolution to saturation
      ST_P1_CHK: begin
        if (i_q >= sts_i.cnt) begin
          cmd_o.keep_all = 1'b1;
          i_d = '0;
          j_d = '0;
          state_d = ST_P2_CHK;
        end else if (j_q >= i_q) begin
          i_d = i_q + CW'(1);
          j_d = '0;
        end else begin
          cmd_o.rd_addr = i_q[AW-1:0];
          state_d = ST_P1_RB;
        end
      end
      ST_P1_RB: begin
        cmd_o.lat_a   = 1'b1;
        cmd_o.rd_addr = j_q[AW-1:0];
        state_d = ST_P1_RES;
      end
      ST_P1_RES: begin
        cmd_o.lat_r = 1'b1;
        k_d = '0;
        state_d = ST_P1_KRD;
      end
      ST_P1_KRD: begin
        if (!sts_i.r_ok) begin
          j_d = j_q + CW'(1);
          state_d = ST_P1_CHK;
        end else begin
          cmd_o.rd_addr = k_q[AW-1:0];
          state_d = ST_P1_KCHK;
        end
      end
      ST_P1_KCHK: begin
        if (sts_i.rd_sub_r) begin
          j_d = j_q + CW'(1);
          state_d = ST_P1_CHK;
        end else if (sts_i.r_sub_rd) begin
          cmd_o.wr_op   = WR_REPL;
          cmd_o.wr_addr = k_q[AW-1:0];
          j_d = j_q + CW'(1);
          state_d = ST_P1_CHK;
        end else if (k_last) begin
          cmd_o.wr_op = WR_APPEND;
          j_d = j_q + CW'(1);
          state_d = ST_P1_CHK;
        end else begin
          k_d = k_q + CW'(1);
          state_d = ST_P1_KRD;
        end
      end
      // Phase 2: mark subsumed clauses
      ST_P2_CHK: begin
        if (i_q >= sts_i.cnt) begin
          i_d = '0;
          w_d = '0;
          pass_d = PASS_SUB;
          state_d = ST_C_CHK;
        end else if (!sts_i.keep[i_q[AW-1:0]] || (j_q >= i_q)) begin
          i_d = i_q + CW'(1);
          j_d = '0;
        end else if (!sts_i.keep[j_q[AW-1:0]]) begin
          j_d = j_q + CW'(1);
        end else begin
          cmd_o.rd_addr = i_q[AW-1:0];
          state_d = ST_P2_RB;
        end
      end
      ST_P2_RB: begin
        cmd_o.lat_a   = 1'b1;
        cmd_o.rd_addr = j_q[AW-1:0];
        state_d = ST_P2_CMP;
      end
      ST_P2_CMP: begin
        state_d = ST_P2_CHK;
        if (sts_i.a_sub_rd) begin
          cmd_o.keep_clr  = 1'b1;
          cmd_o.keep_addr = j_q[AW-1:0];
          j_d = j_q + CW'(1);
        end else if (sts_i.rd_sub_a) begin
          cmd_o.keep_clr  = 1'b1;
          cmd_o.keep_addr = i_q[AW-1:0];
          i_d = i_q + CW'(1);
          j_d = '0;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      // Compaction passes
      ST_C_CHK: begin
        if (i_q >= sts_i.cnt) begin
          cmd_o.cnt_load = 1'b1;
          cmd_o.cnt_val  = w_q;
          i_d = '0;
          j_d = '0;
          w_d = '0;
          case (pass_q)
            PASS_SUB: begin
              pass_d = PASS_PROJ;
            end
            PASS_PROJ: begin
              cmd_o.keep_all = 1'b1;
              state_d = ST_P4_CHK;
            end
            default: begin
              cmd_o.keep_all = 1'b1;
              state_d = ST_E_CHK;
            end
          endcase
        end else begin
          cmd_o.rd_addr = i_q[AW-1:0];
          state_d = ST_C_WR;
        end
      end
      ST_C_WR: begin
        if (keep_ok) begin
          cmd_o.wr_op   = WR_COPY;
          cmd_o.wr_addr = w_q[AW-1:0];
          w_d = w_q + CW'(1);
        end
        i_d = i_q + CW'(1);
        state_d = ST_C_CHK;
      end
      // Phase 4: mark clauses equal to a resolvent
      ST_P4_CHK: begin
        if (i_q >= sts_i.cnt) begin
          i_d = '0;
          w_d = '0;
          pass_d = PASS_RED;
          state_d = ST_C_CHK;
        end else if (j_q >= i_q) begin
          i_d = i_q + CW'(1);
          j_d = '0;
        end else begin
          cmd_o.rd_addr = i_q[AW-1:0];
          state_d = ST_P4_RB;
        end
      end
      ST_P4_RB: begin
        cmd_o.lat_a   = 1'b1;
        cmd_o.rd_addr = j_q[AW-1:0];
        state_d = ST_P4_RES;
      end
      ST_P4_RES: begin
        cmd_o.lat_r = 1'b1;
        k_d = '0;
        state_d = ST_P4_KRD;
      end
      ST_P4_KRD: begin
        if (!sts_i.r_ok) begin
          j_d = j_q + CW'(1);
          state_d = ST_P4_CHK;
        end else begin
          cmd_o.rd_addr = k_q[AW-1:0];
          state_d = ST_P4_KCHK;
        end
      end
      ST_P4_KCHK: begin
        if (sts_i.rd_eq_r) begin
          cmd_o.keep_clr  = 1'b1;
          cmd_o.keep_addr = k_q[AW-1:0];
        end
        if (k_last) begin
          j_d = j_q + CW'(1);
          state_d = ST_P4_CHK;
        end else begin
          k_d = k_q + CW'(1);
          state_d = ST_P4_KRD;
        end
      end
      // Emit survivors
      ST_E_CHK: begin
        if (sts_i.cnt == '0) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_empty = 1'b1;
          cmd_o.emit_last  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          i_d = '0;
          state_d = ST_E_RD;
        end
      end
      ST_E_RD: begin
        cmd_o.rd_addr = i_q[AW-1:0];
        state_d = ST_E_OUT;
      end
      ST_E_OUT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_last = e_last;
        if (e_last) begin
          state_d = ST_IDLE;
        end else begin
          i_d = i_q + CW'(1);
          state_d = ST_E_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/cnf_resolution_subsumption_engine_unit.sv @@
// Load clauses (opcode 0) one per cycle while busy is low; a run (opcode 1)
// raises busy and walks the 64-entry clause table through one RAM read port.
// In resolution and in redundant-resolvent filtering, each clause pair is read
// and resolved, and when it resolves the table is scanned entry by entry;
// subsumption compares each live pair, each compaction visits every entry,
// and emission reads out one survivor at a time. Results appear
// for one cycle on result_valid_o and cannot be held off; an empty table gives
// one result with clause_present_o low.
// Top level; uses crse_pkg, crse_ctrl, crse_datapath and the assertion header.
`default_nettype none
`include "cnf_resolution_subsumption_engine_unit_assert.svh"
module cnf_resolution_subsumption_engine_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode_i,
  input  logic [crse_pkg::FIELD_W-1:0] load_positive_i,
  input  logic [crse_pkg::FIELD_W-1:0] load_negative_i,
  input  logic [crse_pkg::FIELD_W-1:0] project_mask_i,
  output logic                         result_valid_o,
  output logic [crse_pkg::FIELD_W-1:0] clause_positive_o,
  output logic [crse_pkg::FIELD_W-1:0] clause_negative_o,
  output logic                         clause_present_o,
  output logic                         table_overflow_o,
  output logic                         last_clause_o
);
  import crse_pkg::*;

  cmd_t cmd;
  sts_t sts;

  crse_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .opcode_i(opcode_i),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  crse_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_positive_i  (load_positive_i),
    .load_negative_i  (load_negative_i),
    .project_mask_i   (project_mask_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .result_valid_o   (result_valid_o),
    .clause_positive_o(clause_positive_o),
    .clause_negative_o(clause_negative_o),
    .clause_present_o (clause_present_o),
    .table_overflow_o (table_overflow_o),
    .last_clause_o    (last_clause_o)
  );

  // Checks
  `CRSE_ASSERT_IMP(a_more_follow, result_valid_o && !last_clause_o, busy, "run ended early")
  `CRSE_ASSERT_IMP(a_empty_last, result_valid_o && !clause_present_o, last_clause_o, "empty not last")
  `CRSE_ASSERT_NXT(a_ovf_sticky, sts.ovf, sts.ovf, "overflow flag cleared")
  `CRSE_ASSERT_IMP(a_cnt_range, 1'b1, sts.cnt <= CW'(TABLE_DEPTH), "count beyond depth")

endmodule
`default_nettype wire
